@@ sv/bba_pkg.sv @@
// ----------------------------------------------------------------------------
// Buddy block allocator package
// Sizes, types, command and status structs shared by controller and datapath.
// ----------------------------------------------------------------------------
package bba_pkg;

    localparam int LEVELS            = 10;
    localparam int MIN_BLOCK_BYTES   = 1024;
    localparam logic [31:0] REGION_BASE_RESET = 32'h0010_0000;

    localparam int NODE_SLOTS = 1 << LEVELS;
    localparam int WORD_LOG   = (LEVELS < 5) ? LEVELS : 5;
    localparam int WORD_W     = 1 << WORD_LOG;
    localparam int NWORDS     = NODE_SLOTS / WORD_W;
    localparam int WADDR_W    = (NWORDS > 1) ? $clog2(NWORDS) : 1;
    localparam int LVL_W      = $clog2(LEVELS);
    localparam int LB         = $clog2(MIN_BLOCK_BYTES);
    localparam logic [63:0] REGION_BYTES = 64'(MIN_BLOCK_BYTES) << (LEVELS - 1);

    typedef logic [LEVELS-1:0]   t_node;
    typedef logic [WADDR_W-1:0]  t_waddr;
    typedef logic [WORD_W-1:0]   t_word;
    typedef logic [WORD_LOG-1:0] t_bit;
    typedef logic [LVL_W-1:0]    t_lvl;

    typedef enum logic [1:0] {
        STS_OK      = 2'd0,
        STS_NOFIT   = 2'd1,
        STS_BADFREE = 2'd2
    } t_status;

    typedef enum logic {
        FUNC_ALLOC = 1'b0,
        FUNC_FREE  = 1'b1
    } t_func;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_DECODE, ST_SRCH_RD, ST_SRCH_CHK, ST_SPL_RD, ST_SPL_WR,
        ST_ASET_RD, ST_ASET_WR, ST_FCHK_RD, ST_FCHK_CHK, ST_FSET_RD, ST_FSET_WR,
        ST_DONE
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE, OP_CLEAR, OP_LOAD, OP_DECODE, OP_SRCH_RD, OP_SRCH_CHK, OP_SPL_RD,
        OP_SPL_WR, OP_ASET_RD, OP_ASET_WR, OP_FCHK_RD, OP_FCHK_CHK, OP_FSET_RD,
        OP_FSET_WR, OP_OUT
    } t_op;

    typedef struct packed {
        t_op     op;
        t_status sts;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic is_free;
        logic size_bad;
        logic off_bad;
        logic srch_hit;
        logic srch_last;
        logic need_split;
        logic split_more;
        logic fchk_hit;
        logic fchk_fail;
        logic merge;
        logic out_busy;
    } t_dp_stat;

    // Word of the mark memories that holds a node
    function automatic t_waddr word_of(input t_node n);
        t_node t;
        t = n >> WORD_LOG;
        return t[WADDR_W-1:0];
    endfunction

    // Bit position of a node inside its word
    function automatic t_bit bit_of(input t_node n);
        return n[WORD_LOG-1:0];
    endfunction

    // First node of a level in heap order
    function automatic t_node level_first(input t_lvl l);
        return t_node'(1) << (LEVELS - 1 - int'(l));
    endfunction

endpackage

@@ sv/buddy_block_allocator_core.sv @@
// ----------------------------------------------------------------------------
// Buddy block allocator core
// Allocates and frees power-of-two blocks of one region, one request a time.
// ----------------------------------------------------------------------------
//  Channel  Dir  Payload
//  s_axis   in   tdata: request_size[31:0], block_address[63:32]; tuser: func
//  m_axis   out  tdata: result_address[31:0]; tuser: status[1:0]
//  cfg      in   i_cfg_wdata: region_base, written when i_cfg_we is high
//
//  After reset a clearing pass over all NWORDS mark words (32) runs before s_axis_tready.
//  An allocate loads, decodes, scans mark words, splits as needed and sets the
//  allocated mark; a free loads, decodes, probes levels, merges as needed and
//  sets the free mark, each mark update a read-modify-write of a mark memory.
//  A held result stalls only the final step; no new request is taken before it.
module buddy_block_allocator_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // request_size [31:0], block_address [63:32]
    input  logic        s_axis_tuser,   // func [0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // result_address [31:0]
    output logic [1:0]  m_axis_tuser    // status [1:0]
);
    import bba_pkg::*;

    t_cmd     cmd;
    t_dp_stat stat;

    bba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    bba_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_data   (s_axis_tdata),
        .i_in_user   (s_axis_tuser),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata),
        .o_out_user  (m_axis_tuser)
    );

endmodule

@@ sv/bba_ctrl.sv @@
// ----------------------------------------------------------------------------
// Buddy block allocator controller
// Sequences clearing, search, split, lookup and merge steps of the datapath.
// ----------------------------------------------------------------------------
module bba_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  bba_pkg::t_dp_stat i_stat,
    output bba_pkg::t_cmd     o_cmd
);
    import bba_pkg::*;

    t_state  r_state, n_state;
    t_status r_sts, n_sts;

    // State and pending status registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_sts   <= STS_OK;
        end else begin
            r_state <= n_state;
            r_sts   <= n_sts;
        end
    end

    // Next state and datapath commands
    always_comb begin
        n_state    = r_state;
        n_sts      = r_sts;
        o_in_ready = 1'b0;
        o_cmd.op   = OP_NONE;
        o_cmd.sts  = r_sts;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.op = OP_CLEAR;
                if (i_stat.clr_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = ST_DECODE;
                end
            end
            ST_DECODE: begin
                o_cmd.op = OP_DECODE;
                if (i_stat.is_free) begin
                    if (i_stat.off_bad) begin
                        n_sts   = STS_BADFREE;
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_FCHK_RD;
                    end
                end else if (i_stat.size_bad) begin
                    n_sts   = STS_NOFIT;
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_SRCH_RD;
                end
            end
            ST_SRCH_RD: begin
                o_cmd.op = OP_SRCH_RD;
                n_state  = ST_SRCH_CHK;
            end
            ST_SRCH_CHK: begin
                o_cmd.op = OP_SRCH_CHK;
                if (i_stat.srch_hit) begin
                    n_state = i_stat.need_split ? ST_SPL_RD : ST_ASET_RD;
                end else if (i_stat.srch_last) begin
                    n_sts   = STS_NOFIT;
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_SRCH_RD;
                end
            end
            ST_SPL_RD: begin
                o_cmd.op = OP_SPL_RD;
                n_state  = ST_SPL_WR;
            end
            ST_SPL_WR: begin
                o_cmd.op = OP_SPL_WR;
                n_state  = i_stat.split_more ? ST_SPL_RD : ST_ASET_RD;
            end
            ST_ASET_RD: begin
                o_cmd.op = OP_ASET_RD;
                n_state  = ST_ASET_WR;
            end
            ST_ASET_WR: begin
                o_cmd.op = OP_ASET_WR;
                n_sts    = STS_OK;
                n_state  = ST_DONE;
            end
            ST_FCHK_RD: begin
                o_cmd.op = OP_FCHK_RD;
                n_state  = ST_FCHK_CHK;
            end
            ST_FCHK_CHK: begin
                o_cmd.op = OP_FCHK_CHK;
                if (i_stat.fchk_hit) begin
                    n_state = ST_FSET_RD;
                end else if (i_stat.fchk_fail) begin
                    n_sts   = STS_BADFREE;
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_FCHK_RD;
                end
            end
            ST_FSET_RD: begin
                o_cmd.op = OP_FSET_RD;
                n_state  = ST_FSET_WR;
            end
            ST_FSET_WR: begin
                o_cmd.op = OP_FSET_WR;
                if (!i_stat.merge) begin
                    n_sts   = STS_OK;
                    n_state = ST_DONE;
                end else begin
                    n_state = ST_FSET_RD;
                end
            end
            ST_DONE: begin
                if (!i_stat.out_busy) begin
                    o_cmd.op = OP_OUT;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

@@ sv/bba_dp.sv @@
// ----------------------------------------------------------------------------
// Buddy block allocator datapath
// Free and allocated mark memories, search and node registers, output word.
// ----------------------------------------------------------------------------
module bba_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [31:0]       i_cfg_wdata,
    input  logic [63:0]       i_in_data,
    input  logic              i_in_user,
    input  bba_pkg::t_cmd     i_cmd,
    output bba_pkg::t_dp_stat o_stat,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output logic [31:0]       o_out_data,
    output logic [1:0]        o_out_user
);
    import bba_pkg::*;

    t_word r_free_mem  [NWORDS];
    t_word r_alloc_mem [NWORDS];
    t_word r_free_rd, r_alloc_rd;

    logic [31:0] r_base, r_size, r_addr, r_out_addr;
    t_func       r_func;
    t_lvl        r_want, r_lvl;
    t_waddr      r_word;
    t_node       r_node;
    logic        r_ovalid;
    t_status     r_out_sts;

    t_lvl        want_c;
    logic [31:0] off_c, offs_c;
    t_node       lf_c, ll_c, nidx_c, child_c, hit_node_c;
    t_word       lvl_mask_c, cand_c;
    t_bit        hit_bit_c;
    t_waddr      free_ra, alloc_ra, free_wa, alloc_wa;
    t_word       free_wd, alloc_wd;
    logic        free_we, alloc_we;

    // Level for a request size and free offset
    always_comb begin
        want_c = '0;
        for (int l = 0; l < LEVELS - 1; l++) begin
            if ((64'(MIN_BLOCK_BYTES) << l) < {32'd0, r_size}) want_c = want_c + 1'b1;
        end
        off_c = r_addr - r_base;
    end

    // Level window, lowest free node of the current search word, child and offset
    always_comb begin
        lf_c      = level_first(r_lvl);
        ll_c      = (lf_c << 1) - t_node'(1);
        hit_bit_c = '0;
        for (int b = 0; b < WORD_W; b++) begin
            nidx_c        = (t_node'(r_word) << WORD_LOG) | t_node'(b);
            lvl_mask_c[b] = (nidx_c >= lf_c) && (nidx_c <= ll_c);
        end
        cand_c = r_free_rd & lvl_mask_c;
        for (int b = WORD_W - 1; b >= 0; b--) begin
            if (cand_c[b]) hit_bit_c = t_bit'(b);
        end
        hit_node_c = (t_node'(r_word) << WORD_LOG) | t_node'(hit_bit_c);
        child_c    = {r_node[LEVELS-2:0], 1'b0};
        offs_c     = 32'(r_node ^ level_first(r_want)) << (LB + int'(r_want));
    end

    // Status toward the controller
    always_comb begin
        o_stat.clr_last   = (r_word == t_waddr'(NWORDS - 1));
        o_stat.is_free    = (r_func == FUNC_FREE);
        o_stat.size_bad   = ({32'd0, r_size} > REGION_BYTES);
        o_stat.off_bad    = ({32'd0, off_c} >= REGION_BYTES) || (off_c[LB-1:0] != '0);
        o_stat.srch_hit   = |cand_c;
        o_stat.srch_last  = (r_word == word_of(ll_c)) && (r_lvl == t_lvl'(LEVELS - 1));
        o_stat.need_split = (r_lvl != r_want);
        o_stat.split_more = (r_lvl != t_lvl'(r_want + 1'b1));
        o_stat.fchk_hit   = r_alloc_rd[bit_of(r_node)];
        o_stat.fchk_fail  = r_node[0];
        o_stat.merge      = (r_node != t_node'(1)) && r_free_rd[bit_of(r_node ^ t_node'(1))];
        o_stat.out_busy   = r_ovalid && !i_out_ready;
    end

    // Memory addresses and write data
    always_comb begin
        free_ra  = (i_cmd.op == OP_SRCH_RD) ? r_word :
                   (i_cmd.op == OP_SPL_RD) ? word_of(child_c) : word_of(r_node);
        alloc_ra = word_of(r_node);
        free_we  = 1'b0;
        free_wa  = word_of(r_node);
        free_wd  = r_free_rd;
        alloc_we = 1'b0;
        alloc_wa = word_of(r_node);
        alloc_wd = r_alloc_rd;
        case (i_cmd.op)
            OP_CLEAR: begin
                free_we  = 1'b1;
                free_wa  = r_word;
                free_wd  = (r_word == '0) ? (t_word'(1) << 1) : '0;
                alloc_we = 1'b1;
                alloc_wa = r_word;
                alloc_wd = '0;
            end
            OP_SRCH_CHK: begin
                free_we = |cand_c;
                free_wa = r_word;
                free_wd = r_free_rd & ~(t_word'(1) << hit_bit_c);
            end
            OP_SPL_WR: begin
                free_we = 1'b1;
                free_wa = word_of(child_c);
                free_wd = (r_free_rd | (t_word'(1) << bit_of(child_c)))
                          & ~(t_word'(1) << bit_of(child_c | t_node'(1)));
            end
            OP_ASET_WR: begin
                alloc_we = 1'b1;
                alloc_wd = r_alloc_rd | (t_word'(1) << bit_of(r_node));
            end
            OP_FCHK_CHK: begin
                alloc_we = r_alloc_rd[bit_of(r_node)];
                alloc_wd = r_alloc_rd & ~(t_word'(1) << bit_of(r_node));
            end
            OP_FSET_WR: begin
                free_we = 1'b1;
                if (o_stat.merge) begin
                    free_wd = r_free_rd & ~(t_word'(1) << bit_of(r_node))
                              & ~(t_word'(1) << bit_of(r_node ^ t_node'(1)));
                end else begin
                    free_wd = r_free_rd | (t_word'(1) << bit_of(r_node));
                end
            end
            default: ;
        endcase
    end

    // Mark memories with registered reads
    always_ff @(posedge i_clk) begin
        if (free_we) r_free_mem[free_wa] <= free_wd;
        r_free_rd <= r_free_mem[free_ra];
    end

    always_ff @(posedge i_clk) begin
        if (alloc_we) r_alloc_mem[alloc_wa] <= alloc_wd;
        r_alloc_rd <= r_alloc_mem[alloc_ra];
    end

    // Configuration register and word counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= REGION_BASE_RESET;
            r_word <= '0;
        end else begin
            if (i_cfg_we) r_base <= i_cfg_wdata;
            case (i_cmd.op)
                OP_CLEAR:  r_word <= r_word + 1'b1;
                OP_DECODE: r_word <= word_of(level_first(want_c));
                OP_SRCH_CHK: begin
                    if (!(|cand_c)) begin
                        if (r_word == word_of(ll_c)) begin
                            r_word <= word_of(level_first(t_lvl'(r_lvl + 1'b1)));
                        end else begin
                            r_word <= r_word + 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Request, level and node registers
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_func <= t_func'(i_in_user);
                r_size <= i_in_data[31:0];
                r_addr <= i_in_data[63:32];
            end
            OP_DECODE: begin
                r_want <= want_c;
                r_lvl  <= want_c;
                r_node <= {1'b1, off_c[LB +: LEVELS-1]};
            end
            OP_SRCH_CHK: begin
                if (|cand_c) begin
                    r_node <= hit_node_c;
                end else if (r_word == word_of(ll_c)) begin
                    r_lvl <= t_lvl'(r_lvl + 1'b1);
                end
            end
            OP_SPL_WR: begin
                r_node <= child_c | t_node'(1);
                r_lvl  <= t_lvl'(r_lvl - 1'b1);
            end
            OP_FCHK_CHK: begin
                if (!r_alloc_rd[bit_of(r_node)]) r_node <= r_node >> 1;
            end
            OP_FSET_WR: begin
                if (o_stat.merge) r_node <= r_node >> 1;
            end
            default: ;
        endcase
    end

    // Output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.op == OP_OUT) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_OUT) begin
            r_out_sts  <= i_cmd.sts;
            r_out_addr <= (i_cmd.sts == STS_OK && r_func == FUNC_ALLOC) ?
                          (r_base + offs_c) : '0;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out_addr;
    assign o_out_user  = r_out_sts;

endmodule
